// File: src/dld4_pkg.sv
package dld4_pkg;

  localparam int ValueBitsDef = 20;

  localparam logic [7:0] CodeSampleStart = 8'h40;
  localparam logic [7:0] CodeDecoUp      = 8'hAB;
  localparam logic [7:0] CodeDecoDown    = 8'hAD;
  localparam logic [15:0] CeilingStep    = 16'd10;
  localparam logic [19:0] TempOffset     = 20'd80;

  localparam logic [1:0] RegStartDepth = 2'd0;
  localparam logic [1:0] RegStartTemp  = 2'd1;
  localparam logic [1:0] RegStartTank  = 2'd2;
  localparam logic [1:0] RegInterval   = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SAMPLE = 2'd1,
    PH_DECO   = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    KIND_DEPTH      = 4'd0,
    KIND_TEMP       = 4'd1,
    KIND_TANK       = 4'd2,
    KIND_EVENT      = 4'd3,
    KIND_FIRST_STOP = 4'd4,
    KIND_DECO_TOTAL = 4'd5,
    KIND_ASCENT     = 4'd6,
    KIND_GAS_RATE   = 4'd7,
    KIND_INTERDIVE  = 4'd8
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [31:0]        time_sec;
    logic signed [19:0] reading;
    logic [15:0]        ceiling;
    logic [7:0]         code;
    logic [31:0]        stamp;
  } rec_t;

  // One decoded input word: optional opening values, then up to two records.
  typedef struct packed {
    logic               init_en;
    logic signed [19:0] init_depth;
    logic [15:0]        init_temp;
    logic signed [19:0] init_tank;
    logic [1:0]         nmain;
    rec_t [1:0]         rec;
  } job_t;

  function automatic logic [4:0] record_len(logic [7:0] c);
    logic [4:0] len;
    begin
      unique case (c) inside
        8'h00, 8'h03: len = 5'd16;
        8'h01, 8'h10: len = 5'd20;
        8'h02: len = 5'd17;
        [8'h06:8'h0e]: len = 5'd18;
        default: len = 5'd0;
      endcase
      return len;
    end
  endfunction

  function automatic rec_t mk_rec(kind_e k, logic [31:0] t, logic signed [19:0] rd,
                                  logic [15:0] ce, logic [7:0] cd, logic [31:0] st);
    rec_t r;
    begin
      r.kind = k;
      r.time_sec = t;
      r.reading = rd;
      r.ceiling = ce;
      r.code = cd;
      r.stamp = st;
      return r;
    end
  endfunction

endpackage

// File: src/dld4_front.sv
module dld4_front #(
  parameter int ValueBits = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            first_byte_i,
  input  logic            last_byte_i,
  output logic            push_o,
  output dld4_pkg::job_t  job_o,
  input  logic            full_i
);
  import dld4_pkg::*;

  localparam int VB = ValueBits;

  logic [15:0] start_depth_q, start_temp_q, start_tank_q;
  logic [7:0]  interval_q;

  phase_e                phase_q, phase_d;
  logic                  init_q, init_d, slot_q, slot_d;
  logic [1:0]            rot_q, rot_d;
  logic [4:0]            pend_q, pend_d;
  logic [31:0]           gath_q, gath_d, tm_q, tm_d;
  logic [7:0]            code_q, code_d;
  logic signed [VB-1:0]  dep_q, dep_d, tank_q, tank_d, gas_q, gas_d;
  logic [15:0]           ceil_q, ceil_d;
  logic                  accept;
  job_t                  job;

  function automatic logic signed [VB-1:0] sat_add(logic signed [VB-1:0] a,
                                                   logic signed [8:0] d);
    logic signed [VB:0] s;
    begin
      s = {a[VB-1], a} + {{(VB-8){d[8]}}, d};
      if (s[VB] != s[VB-1]) begin
        return s[VB] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
      end
      return s[VB-1:0];
    end
  endfunction

  function automatic logic signed [19:0] to_rd(logic signed [VB-1:0] v);
    logic signed [32:0] w;
    begin
      w = 33'(v);
      if (w > 33'sd524287) return 20'sd524287;
      if (w < -33'sd524288) return -20'sd524288;
      return w[19:0];
    end
  endfunction

  function automatic logic signed [VB-1:0] sat_start(logic [15:0] v);
    logic [32:0] w, hi;
    begin
      w = {17'd0, v};
      hi = (33'd1 << (VB - 1)) - 33'd1;
      return (w > hi) ? hi[VB-1:0] : w[VB-1:0];
    end
  endfunction

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = full_i;

  always_comb begin
    logic [7:0] b;
    logic [6:0] mag;
    logic [4:0] idx5;
    logic [1:0] idx;
    logic [16:0] c17;
    logic signed [8:0] d9;
    rec_t r0, r1;
    logic [1:0] nm;
    b = data_byte_i;
    mag = b[6:0];
    idx5 = '0;
    idx = '0;
    c17 = '0;
    d9 = '0;
    r0 = '0;
    r1 = '0;
    nm = 2'd0;
    phase_d = phase_q; init_d = init_q; slot_d = slot_q; rot_d = rot_q;
    pend_d = pend_q; gath_d = gath_q; code_d = code_q; dep_d = dep_q;
    tank_d = tank_q; gas_d = gas_q; ceil_d = ceil_q; tm_d = tm_q;
    job = '0;
    if (first_byte_i) begin
      phase_d = PH_HEADER; init_d = 1'b0; slot_d = 1'b0; rot_d = 2'd0;
      pend_d = '0; gath_d = '0; code_d = '0;
      dep_d = sat_start(start_depth_q); tank_d = sat_start(start_tank_q);
      gas_d = '0; ceil_d = '0; tm_d = '0;
    end
    if (phase_d == PH_HEADER && pend_d != 5'd0) begin
      idx5 = record_len(code_d) - pend_d;
      if (idx5 < 5'd4) gath_d[idx5[1:0]*8 +: 8] = gath_d[idx5[1:0]*8 +: 8] | b;
      pend_d = pend_d - 5'd1;
      if (pend_d == 5'd0 && !last_byte_i) begin
        r0 = mk_rec(KIND_INTERDIVE, 32'd0, 20'sd0, 16'd0, code_d, gath_d);
        nm = 2'd1;
      end
    end else if (phase_d == PH_HEADER && !b[7] && b != CodeSampleStart) begin
      code_d = b;
      gath_d = '0;
      pend_d = record_len(b);
    end else if (phase_d == PH_DECO) begin
      if (pend_d > 5'd4 || pend_d == 5'd0) pend_d = 5'd4;
      idx = 2'(5'd4 - pend_d);
      gath_d[idx*8 +: 8] = gath_d[idx*8 +: 8] | b;
      pend_d = pend_d - 5'd1;
      if (pend_d == 5'd0) begin
        r0 = mk_rec(KIND_FIRST_STOP, tm_d, 20'({4'd0, gath_d[15:0]} + 20'd1), ceil_d,
                    8'd0, 32'd0);
        r1 = mk_rec(KIND_DECO_TOTAL, tm_d, 20'({4'd0, gath_d[31:16]} + 20'd1), 16'd0,
                    8'd0, 32'd0);
        nm = 2'd2;
        phase_d = PH_SAMPLE;
      end
    end else begin
      if (phase_d == PH_HEADER) begin
        phase_d = PH_SAMPLE;
        if (!init_d) begin
          init_d = 1'b1;
          job.init_en = 1'b1;
        end
      end
      if (!slot_d) begin
        if (b[7]) begin
          r0 = mk_rec(KIND_EVENT, tm_d, 20'sd0, 16'd0, b, 32'd0);
          nm = 2'd1;
          if (b == CodeDecoUp || b == CodeDecoDown) begin
            if (b == CodeDecoUp) begin
              c17 = {1'b0, ceil_d} + {1'b0, CeilingStep};
              ceil_d = c17[16] ? 16'hFFFF : c17[15:0];
            end else begin
              ceil_d = (ceil_d < CeilingStep) ? 16'd0 : ceil_d - CeilingStep;
            end
            phase_d = PH_DECO;
            pend_d = 5'd4;
            gath_d = '0;
          end
        end else begin
          tm_d = tm_d + {24'd0, interval_q};
          d9 = {3'b000, b[5:0]};
          dep_d = sat_add(dep_d, b[6] ? -d9 : d9);
          r0 = mk_rec(KIND_DEPTH, tm_d, to_rd(dep_d), 16'd0, 8'd0, 32'd0);
          nm = 2'd1;
          slot_d = 1'b1;
        end
      end else begin
        d9 = {2'b00, mag};
        case (rot_d)
          2'd0: r0 = mk_rec(KIND_ASCENT, tm_d, b[7] ? 20'(d9) : -20'(d9), 16'd0, 8'd0,
                            32'd0);
          2'd1: begin
            gas_d = sat_add(gas_d, b[7] ? -d9 : d9);
            r0 = mk_rec(KIND_GAS_RATE, tm_d, to_rd(gas_d), 16'd0, 8'd0, 32'd0);
          end
          2'd2: begin
            tank_d = sat_add(tank_d, b[7] ? -d9 : d9);
            r0 = mk_rec(KIND_TANK, tm_d, to_rd(tank_d), 16'd0, 8'd0, 32'd0);
          end
          default: r0 = mk_rec(KIND_TEMP, tm_d, 20'({mag, 1'b0}) + TempOffset, 16'd0,
                               8'd0, 32'd0);
        endcase
        nm = 2'd1;
        rot_d = rot_d + 2'd1;
        slot_d = 1'b0;
      end
    end
    if (last_byte_i && phase_d == PH_HEADER) begin
      if (!init_d) begin
        init_d = 1'b1;
        job.init_en = 1'b1;
      end
      phase_d = PH_SAMPLE;
      pend_d = '0;
    end
    job.init_depth = to_rd(dep_d);
    job.init_temp = start_temp_q;
    job.init_tank = to_rd(tank_d);
    job.nmain = nm;
    job.rec[0] = r0;
    job.rec[1] = r1;
  end

  assign job_o = job;
  assign push_o = accept && (job.init_en || job.nmain != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_depth_q <= '0; start_temp_q <= '0; start_tank_q <= '0; interval_q <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegStartDepth: start_depth_q <= cfg_data_i;
        RegStartTemp:  start_temp_q <= cfg_data_i;
        RegStartTank:  start_tank_q <= cfg_data_i;
        default:       interval_q <= cfg_data_i[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; init_q <= 1'b0; slot_q <= 1'b0; rot_q <= '0;
      pend_q <= '0; gath_q <= '0; code_q <= '0; dep_q <= '0; tank_q <= '0;
      gas_q <= '0; ceil_q <= '0; tm_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d; init_q <= init_d; slot_q <= slot_d; rot_q <= rot_d;
      pend_q <= pend_d; gath_q <= gath_d; code_q <= code_d; dep_q <= dep_d;
      tank_q <= tank_d; gas_q <= gas_d; ceil_q <= ceil_d; tm_q <= tm_d;
    end
  end

  a_deco_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DECO |-> pend_q != 5'd0 && pend_q <= 5'd4)
    else $error("deco phase without a pending count");

endmodule

// File: src/dld4_queue.sv
module dld4_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dld4_pkg::job_t data_i,
  output logic           full_o,
  output logic           valid_o,
  output dld4_pkg::job_t data_o,
  input  logic           pop_i
);
  import dld4_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o)) else $error("queue read while empty");

endmodule

// File: src/dld4_back.sv
module dld4_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  dld4_pkg::job_t     job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         record_kind_o,
  output logic [31:0]        time_sec_o,
  output logic signed [19:0] reading_o,
  output logic [15:0]        ceiling_ft_o,
  output logic [7:0]         code_byte_o,
  output logic [31:0]        stamp_raw_o,
  output logic               run_end_o
);
  import dld4_pkg::*;

  logic [2:0] idx_q, nb, total, m;
  logic       load, last;
  logic       valid_q, end_q;
  rec_t       sel, out_q;

  assign nb = job_i.init_en ? 3'd3 : 3'd0;
  assign total = nb + {1'b0, job_i.nmain};
  assign last = idx_q == total - 3'd1;
  assign m = idx_q - nb;
  assign load = valid_i && (!valid_q || !out_stall_i);
  assign pop_o = load && last;

  always_comb begin
    sel = job_i.rec[m[0]];
    if (idx_q < nb) begin
      case (idx_q[1:0])
        2'd0: sel = mk_rec(KIND_DEPTH, 32'd0, job_i.init_depth, 16'd0, 8'd0, 32'd0);
        2'd1: sel = mk_rec(KIND_TEMP, 32'd0, 20'({4'd0, job_i.init_temp}), 16'd0, 8'd0,
                           32'd0);
        default: sel = mk_rec(KIND_TANK, 32'd0, job_i.init_tank, 16'd0, 8'd0, 32'd0);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= sel;
      end_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0; idx_q <= '0;
    end else begin
      if (load) idx_q <= last ? 3'd0 : idx_q + 3'd1;
      if (load) valid_q <= 1'b1;
      else if (!out_stall_i) valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign record_kind_o = out_q.kind;
  assign time_sec_o = out_q.time_sec;
  assign reading_o = out_q.reading;
  assign ceiling_ft_o = out_q.ceiling;
  assign code_byte_o = out_q.code;
  assign stamp_raw_o = out_q.stamp;
  assign run_end_o = end_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> idx_q < total) else $error("result index beyond the word");

endmodule

// File: src/delta_log_decoder_four_phase_top.sv
// Decodes a dive-log byte stream, one byte per word, into result words. The front
// end takes a byte every cycle while the two-entry queue has room; the back end
// sends one result per cycle while the output is not stalled; a byte gives at most
// one result, the opening byte of a log up to four and a deco record's last byte two.
// The queue lets a new byte enter while a result still waits to be taken.
module delta_log_decoder_four_phase_top #(
  parameter int ValueBits = dld4_pkg::ValueBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               first_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         record_kind_o,
  output logic [31:0]        time_sec_o,
  output logic signed [19:0] reading_o,
  output logic [15:0]        ceiling_ft_o,
  output logic [7:0]         code_byte_o,
  output logic [31:0]        stamp_raw_o,
  output logic               run_end_o
);
  import dld4_pkg::*;

  logic push, full, q_valid, pop;
  job_t push_job, head_job;

  dld4_front #(.ValueBits(ValueBits)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .data_byte_i, .first_byte_i, .last_byte_i,
    .push_o(push), .job_o(push_job), .full_i(full)
  );

  dld4_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_job), .full_o(full),
    .valid_o(q_valid), .data_o(head_job), .pop_i(pop)
  );

  dld4_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .job_i(head_job), .pop_o(pop),
    .out_valid_o, .out_stall_i, .record_kind_o, .time_sec_o, .reading_o,
    .ceiling_ft_o, .code_byte_o, .stamp_raw_o, .run_end_o
  );

endmodule

// File: tb/testbench.sv
module testbench;
  import dld4_pkg::*;

  typedef struct {
    kind_e              kind;
    logic [31:0]        tsec;
    logic signed [19:0] rd;
    logic [15:0]        ceil;
    logic [7:0]         code;
    logic [31:0]        stamp;
    bit                 fin;
  } log_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = RegStartDepth;
  logic [15:0] cfg_data_i = 16'd0;
  logic in_valid_i = 1'b0;
  logic [7:0] data_byte_i = 8'd0;
  logic first_byte_i = 1'b0;
  logic last_byte_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o, run_end_o;
  logic [3:0] record_kind_o;
  logic [31:0] time_sec_o, stamp_raw_o;
  logic signed [19:0] reading_o;
  logic [15:0] ceiling_ft_o;
  logic [7:0] code_byte_o;

  delta_log_decoder_four_phase_top DUT (.*);

  always #5 clk_i = ~clk_i;

  // Decoder state as the predictor keeps it.
  logic [15:0] cfg_depth = 0, cfg_temp = 0, cfg_tank = 0;
  logic [7:0] cfg_interval = 8'd1;
  phase_e ph;
  bit init_done, slot;
  logic [1:0] rot;
  int pend, ceil_acc;
  logic [31:0] gath, time_acc;
  logic [7:0] held;
  longint depth_acc, tank_acc, gas_acc;

  log_rec_t expected_recs[$];
  log_rec_t step_recs[$];
  int errors = 0, words_in = 0, words_out = 0, idle_pct = 0, stall_pct = 0;
  int quiet = 0;
  bit hold_on = 1'b0;

  function automatic longint clamp20(longint v);
    return v > 524287 ? 524287 : (v < -524288 ? -524288 : v);
  endfunction

  function automatic int header_len(logic [7:0] c);
    if (c == 8'h00 || c == 8'h03) return 16;
    if (c == 8'h01 || c == 8'h10) return 20;
    if (c == 8'h02) return 17;
    if (c >= 8'h06 && c <= 8'h0e) return 18;
    return 0;
  endfunction

  function automatic void add_rec(kind_e k, logic [31:0] t, longint rd, logic [15:0] ce,
                                  logic [7:0] cd, logic [31:0] st);
    log_rec_t r;
    r.kind = k; r.tsec = t; r.rd = clamp20(rd); r.ceil = ce; r.code = cd; r.stamp = st;
    r.fin = 0;
    if (step_recs.size() < 5) step_recs.push_back(r);
  endfunction

  function automatic void restart_log();
    ph = PH_HEADER; init_done = 0; slot = 0; rot = 0; pend = 0; gath = 0; held = 0;
    depth_acc = cfg_depth; tank_acc = cfg_tank; gas_acc = 0; ceil_acc = 0; time_acc = 0;
  endfunction

  function automatic void opening_values();
    if (!init_done) begin
      init_done = 1;
      add_rec(KIND_DEPTH, 0, depth_acc, 0, 0, 0);
      add_rec(KIND_TEMP, 0, cfg_temp, 0, 0, 0);
      add_rec(KIND_TANK, 0, tank_acc, 0, 0, 0);
    end
  endfunction

  function automatic void decode_sample(logic [7:0] b);
    longint mag;
    mag = b & 8'h7f;
    if (!slot) begin
      if (b[7]) begin
        add_rec(KIND_EVENT, time_acc, 0, 0, b, 0);
        if (b == CodeDecoUp || b == CodeDecoDown) begin
          ceil_acc += (b == CodeDecoUp) ? 10 : -10;
          if (ceil_acc < 0) ceil_acc = 0;
          if (ceil_acc > 65535) ceil_acc = 65535;
          ph = PH_DECO; pend = 4; gath = 0;
        end
      end else begin
        time_acc += cfg_interval;
        depth_acc = clamp20(depth_acc + (b[6] ? -longint'(b & 8'h3f) : longint'(b & 8'h3f)));
        add_rec(KIND_DEPTH, time_acc, depth_acc, 0, 0, 0);
        slot = 1;
      end
    end else begin
      case (rot)
        2'd0: add_rec(KIND_ASCENT, time_acc, b[7] ? mag : -mag, 0, 0, 0);
        2'd1: begin
          gas_acc = clamp20(gas_acc + (b[7] ? -mag : mag));
          add_rec(KIND_GAS_RATE, time_acc, gas_acc, 0, 0, 0);
        end
        2'd2: begin
          tank_acc = clamp20(tank_acc + (b[7] ? -mag : mag));
          add_rec(KIND_TANK, time_acc, tank_acc, 0, 0, 0);
        end
        default: add_rec(KIND_TEMP, time_acc, mag * 2 + 80, 0, 0, 0);
      endcase
      rot = rot + 2'd1;
      slot = 0;
    end
  endfunction

  function automatic void predict_word(logic [7:0] b, bit f, bit l);
    int idx;
    step_recs.delete();
    if (f) restart_log();
    if (ph == PH_HEADER) begin
      if (pend > 0) begin
        idx = header_len(held) - pend;
        if (idx < 4) gath |= 32'(b) << (8 * idx);
        pend--;
        if (pend == 0 && !l) add_rec(KIND_INTERDIVE, 0, 0, 0, held, gath);
      end else if (!b[7] && b != CodeSampleStart) begin
        held = b; gath = 0; pend = header_len(b);
      end else begin
        ph = PH_SAMPLE;
        opening_values();
        decode_sample(b);
      end
      if (l && ph == PH_HEADER) begin
        opening_values();
        ph = PH_SAMPLE; pend = 0;
      end
    end else if (ph == PH_DECO) begin
      if (pend > 4 || pend == 0) pend = 4;
      gath |= 32'(b) << (8 * (4 - pend));
      pend--;
      if (pend == 0) begin
        add_rec(KIND_FIRST_STOP, time_acc, (gath & 32'hffff) + 1, ceil_acc[15:0], 0, 0);
        add_rec(KIND_DECO_TOTAL, time_acc, (gath >> 16) + 1, 0, 0, 0);
        ph = PH_SAMPLE;
      end
    end else begin
      decode_sample(b);
    end
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].fin = 1;
    foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
  endfunction

  // Receiver: stalls, checks each taken result and keeps the watchdog.
  always @(posedge clk_i) begin
    log_rec_t e;
    if (hold_on) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
    if (rst_ni && (out_valid_o && !out_stall_i || in_valid_i && !in_stall_o)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 3000) begin
      $display("%0t: timeout, %0d results outstanding", $realtime, expected_recs.size());
      $display("FAILED: results differ");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_out++;
      if (expected_recs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0d reading %0d", $realtime, record_kind_o,
                 reading_o);
      end else begin
        e = expected_recs.pop_front();
        if (record_kind_o !== e.kind || time_sec_o !== e.tsec || reading_o !== e.rd ||
            ceiling_ft_o !== e.ceil || code_byte_o !== e.code || stamp_raw_o !== e.stamp ||
            run_end_o !== e.fin) begin
          errors++;
          $display("%0t: expected kind %0d time %0d reading %0d ceiling %0d code %h stamp %h end %0d",
                   $realtime, e.kind, e.tsec, e.rd, e.ceil, e.code, e.stamp, e.fin);
          $display("%0t: actual   kind %0d time %0d reading %0d ceiling %0d code %h stamp %h end %0d",
                   $realtime, record_kind_o, time_sec_o, reading_o, ceiling_ft_o, code_byte_o,
                   stamp_raw_o, run_end_o);
        end
      end
    end
  end

  task automatic send_word(logic [7:0] b, bit f, bit l);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    first_byte_i <= f;
    last_byte_i <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(b, f, l);
    words_in++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_recs.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegStartDepth: cfg_depth = val;
      RegStartTemp:  cfg_temp = val;
      RegStartTank:  cfg_tank = val;
      default:       cfg_interval = val[7:0];
    endcase
  endtask

  task automatic set_regs(logic [15:0] d, logic [15:0] t, logic [15:0] k, logic [7:0] iv);
    drain();
    write_reg(RegStartDepth, d);
    write_reg(RegStartTemp, t);
    write_reg(RegStartTank, k);
    write_reg(RegInterval, {8'd0, iv});
  endtask

  task automatic send_log(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_word(bytes[i], i == 0, i == bytes.size() - 1);
  endtask

  // A log, at times cut short: optional header records, a start byte, samples, events.
  task automatic random_log();
    logic [7:0] bytes[$];
    logic [7:0] codes[] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h06, 8'h0e, 8'h10, 8'h05};
    logic [7:0] c;
    int n;
    n = $urandom_range(2);
    repeat (n) begin
      c = codes[$urandom_range(codes.size() - 1)];
      bytes.push_back(c);
      repeat (header_len(c)) bytes.push_back(8'($urandom_range(255)));
    end
    bytes.push_back($urandom_range(1) ? CodeSampleStart : 8'(8'h80 | $urandom_range(127)));
    repeat ($urandom_range(4, 14)) begin
      case ($urandom_range(9))
        0: begin
          bytes.push_back($urandom_range(1) ? CodeDecoUp : CodeDecoDown);
          repeat (4) bytes.push_back(8'($urandom_range(255)));
        end
        1: bytes.push_back(8'(8'h80 | $urandom_range(127)));
        default: begin
          bytes.push_back(8'($urandom_range(127)));
          bytes.push_back(8'($urandom_range(255)));
        end
      endcase
    end
    if ($urandom_range(3) == 0) void'(bytes.pop_back());
    send_log(bytes);
  endtask

  task automatic test_headers();
    logic [7:0] bytes[$];
    bytes = '{8'h01};
    repeat (20) bytes.push_back(8'hff);
    bytes.push_back(8'h05);
    bytes.push_back(8'h02);
    for (int i = 0; i < 17; i++) bytes.push_back(8'(i * 15));
    bytes.push_back(8'h40);
    bytes.push_back(8'h3f);
    bytes.push_back(8'h00);
    send_log(bytes);
    bytes = '{8'h03, 8'h11, 8'h22};
    send_log(bytes);
    bytes = '{8'h00};
    repeat (16) bytes.push_back(8'h5a);
    send_log(bytes);
  endtask

  task automatic test_samples();
    logic [7:0] bytes[$];
    bytes = '{8'h40, 8'h3f, 8'h00, 8'h7f, 8'hff, 8'h00, 8'h7f, 8'h40, 8'h80,
              8'hAD, 8'hff, 8'hff, 8'hff, 8'hff, 8'hAB, 8'h00, 8'h00, 8'h01, 8'h00,
              8'h01, 8'hff, 8'hc3, 8'h12};
    send_log(bytes);
    send_word(8'h7f, 0, 0);
  endtask

  task automatic test_random(int words);
    int start;
    start = words_in;
    while (words_in - start < words) begin
      if ($urandom_range(9) == 0)
        send_word(8'($urandom_range(255)), $urandom_range(3) == 0, $urandom_range(3) == 0);
      else
        random_log();
    end
  endtask

  task automatic test_pressure();
    fork
      begin
        hold_on <= 1'b1;
        repeat (80) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join_none
    repeat (20) send_word(8'($urandom_range(127)), 0, 0);
    drain();
    repeat (10) send_word(8'($urandom_range(255)), 0, 0);
  endtask

  initial begin
    restart_log();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_headers();
    set_regs(16'hffff, 16'hffff, 16'hffff, 8'd255);
    test_samples();
    set_regs(16'd0, 16'd0, 16'd0, 8'd1);
    test_samples();
    test_pressure();
    set_regs(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)));
    test_random(30);
    idle_pct = 82;
    test_random(30);
    set_regs(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)));
    idle_pct = 0;
    stall_pct = 82;
    test_random(30);
    idle_pct = 7;
    stall_pct = 7;
    test_random(30);
    drain();
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d input words and %0d results: header records, samples,",
             words_in, words_out);
    $display("events, deco records, register extremes, stalls and idle gaps.");
    if (errors == 0 && expected_recs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: delta_log_decoder_four_phase_top.f
src/dld4_pkg.sv
src/dld4_front.sv
src/dld4_queue.sv
src/dld4_back.sv
src/delta_log_decoder_four_phase_top.sv
tb/testbench.sv
